// File: rtl/circular_first_free_slot_allocator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circular first-free slot allocator
// Concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIRST_FREE_SLOT_ALLOCATOR_DEFINES_SVH
`define CIRCULAR_FIRST_FREE_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define CFFSA_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define CFFSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CFFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CFFSA_ASSERT(lbl, clk, rst_n, expr)
`define CFFSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/cffsa_pkg.sv
// ----------------------------------------------------------------------------
// Circular first-free slot allocator package
// Sizes, codes and types shared by the allocator and its word scanner.
// ----------------------------------------------------------------------------
package cffsa_pkg;

	localparam int MAX_PLACES = 256;
	localparam int PLACE_W    = 9;
	localparam int TDATA_W    = ((PLACE_W + 7) / 8) * 8;
	localparam int WORD_W     = (MAX_PLACES < 16) ? MAX_PLACES : 16;
	localparam int NUM_WORDS  = (MAX_PLACES + WORD_W - 1) / WORD_W;
	localparam int BIT_W      = (WORD_W > 1) ? $clog2(WORD_W) : 1;
	localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int G_W        = WIDX_W + BIT_W;
	localparam int CNT_W      = $clog2(MAX_PLACES + 1);
	localparam int CMP_W      = ((PLACE_W > CNT_W) ? PLACE_W : CNT_W) + G_W;

	localparam logic FUNC_ALLOC   = 1'b0;
	localparam logic FUNC_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	typedef struct packed {
		logic [WIDX_W-1:0] word;
		logic [CMP_W-1:0]  lo;
		logic [CMP_W-1:0]  hi;
	} scan_ctl_t;

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] bit_idx;
	} scan_res_t;

endpackage

// File: rtl/cffsa_word_scan.sv
// ----------------------------------------------------------------------------
// Word scanner
// Finds the lowest free slot of one occupancy word inside a slot window.
// ----------------------------------------------------------------------------
module cffsa_word_scan
	import cffsa_pkg::*;
(
	input  logic [WORD_W-1:0] occ_word,
	input  scan_ctl_t         ctl,
	output scan_res_t         res
);

	logic [WORD_W-1:0] cand;

	always_comb begin
		logic [CMP_W-1:0] g;
		for (int b = 0; b < WORD_W; b++) begin
			g = CMP_W'({ctl.word, BIT_W'(b)});
			cand[b] = !occ_word[b] && (g >= ctl.lo) && (g < ctl.hi);
		end
	end

	always_comb begin
		res.found   = 1'b0;
		res.bit_idx = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				res.found   = 1'b1;
				res.bit_idx = BIT_W'(b);
			end
		end
	end

endmodule

// File: rtl/circular_first_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// Circular first-free slot allocator
// Grants the first free slot at or after a preferred slot on a ring and
// frees slots on release requests.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         request: tuser = func, tdata = place
//  m_*       out        grant:   tdata = granted_place, tuser = full_res
//  cfg_*     in         num_places register write
//
//  A release request completes in its accept cycle. An allocate request is
//  accepted and then scanned, one occupancy word of WORD_W slots per cycle
//  through the shared word scanner.
//  Reset frees every slot at once and sets num_places to MAX_PLACES.
//  A scan that ends while a grant is still waiting at the output holds until
//  the output register is free.
// ----------------------------------------------------------------------------
`include "circular_first_free_slot_allocator_defines.svh"

module circular_first_free_slot_allocator
	import cffsa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,     // [8:0] place
	input  logic               s_tuser,     // [0] func
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,     // [8:0] granted_place
	output logic               m_tuser,     // [0] full_res
	input  logic               cfg_wr_en,
	input  logic [PLACE_W-1:0] cfg_wr_data
);

	state_t                         state_q;
	logic [PLACE_W-1:0]             num_q;
	logic [NUM_WORDS-1:0][WORD_W-1:0] occ_q;
	logic [G_W-1:0]                 start_q;
	logic [WIDX_W-1:0]              word_q;
	logic                           wrapped_q;
	logic                           m_valid_q;
	logic [PLACE_W-1:0]             granted_q;
	logic                           full_q;

	logic [CNT_W-1:0]   ring_n;
	logic [CMP_W-1:0]   place_x;
	logic [CMP_W-1:0]   ring_x;
	logic               place_ok;
	logic [G_W-1:0]     place_idx;
	logic [G_W-1:0]     last_idx;
	logic [WIDX_W-1:0]  last_word;
	logic [WIDX_W-1:0]  start_word;
	logic               at_start;
	logic               scan_last;
	logic               out_free;
	logic               req_acc;
	logic               grant_fire;
	logic [G_W-1:0]     hit_idx;
	scan_ctl_t          ctl;
	scan_res_t          res;

	always_comb begin
		if (num_q == '0) begin
			ring_n = CNT_W'(1);
		end else if (CMP_W'(num_q) > CMP_W'(MAX_PLACES)) begin
			ring_n = CNT_W'(MAX_PLACES);
		end else begin
			ring_n = CNT_W'(num_q);
		end
	end

	assign place_x    = CMP_W'(s_tdata[PLACE_W-1:0]);
	assign ring_x     = CMP_W'(ring_n);
	assign place_ok   = (place_x != '0) && (place_x <= ring_x);
	assign place_idx  = G_W'(place_x - CMP_W'(1));
	assign last_idx   = G_W'(ring_x - CMP_W'(1));
	assign last_word  = last_idx[G_W-1:BIT_W];
	assign start_word = start_q[G_W-1:BIT_W];
	assign at_start   = (word_q == start_word);

	assign s_tready = (state_q == ST_IDLE);
	assign req_acc  = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		ctl.word = word_q;
		ctl.lo   = (at_start && !wrapped_q) ? CMP_W'(start_q) : '0;
		ctl.hi   = (at_start && wrapped_q) ? CMP_W'(start_q) : ring_x;
	end

	cffsa_word_scan u_scan (
		.occ_word (occ_q[word_q]),
		.ctl      (ctl),
		.res      (res)
	);

	assign scan_last  = res.found || (at_start && wrapped_q);
	assign hit_idx    = {word_q, res.bit_idx};
	assign grant_fire = (state_q == ST_SCAN) && scan_last && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= PLACE_W'(MAX_PLACES);
		end else if (cfg_wr_en) begin
			num_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (grant_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			occ_q     <= '0;
			word_q    <= '0;
			wrapped_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (s_tuser == FUNC_RELEASE) begin
							if (place_ok) begin
								occ_q[place_idx[G_W-1:BIT_W]][place_idx[BIT_W-1:0]] <= 1'b0;
							end
						end else begin
							word_q    <= place_ok ? place_idx[G_W-1:BIT_W] : '0;
							wrapped_q <= 1'b0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						if (out_free) begin
							if (res.found) begin
								occ_q[word_q][res.bit_idx] <= 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end else if (word_q == last_word) begin
						word_q    <= '0;
						wrapped_q <= 1'b1;
					end else begin
						word_q <= word_q + WIDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && s_tuser == FUNC_ALLOC) begin
			start_q <= place_ok ? place_idx : '0;
		end
		if (grant_fire) begin
			granted_q <= res.found ? PLACE_W'(CMP_W'(hit_idx) + CMP_W'(1)) : '0;
			full_q    <= !res.found;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDATA_W'(granted_q);
	assign m_tuser  = full_q;

	`CFFSA_ASSERT_IMP(a_full_gives_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	`CFFSA_ASSERT_IMP(a_hit_is_free, clk, arst_n,
		state_q == ST_SCAN && res.found, !occ_q[word_q][res.bit_idx])
	`CFFSA_ASSERT_NEXT(a_release_no_result, clk, arst_n,
		req_acc && s_tuser == FUNC_RELEASE && !(m_tvalid && m_tready),
		m_tvalid == $past(m_tvalid))

endmodule
